@@ hdl/plucker_line_line_intersect_assert.svh @@
// Assertion macros used by the checker of the line intersection block.
`ifndef PLUCKER_LINE_LINE_INTERSECT_ASSERT_SVH
`define PLUCKER_LINE_LINE_INTERSECT_ASSERT_SVH

// Same-cycle implication, disabled while rs is high.
`define PLLI_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rs is high.
`define PLLI_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plli_pkg.sv @@
// Constants and helpers for the Pluecker line intersection block.
package plli_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int NUM_COORDS         = 6;
  localparam int OUT_BITS           = 33;
  localparam int OUT_FIELDS         = 8;
  localparam int OUT_DATA_BITS      = OUT_FIELDS * OUT_BITS;
  localparam int TOL_BITS           = 32;
  localparam int APB_DATA_BITS      = 32;
  localparam int APB_ADDR_BITS      = 1;
  localparam int TRACE_LIMIT_LOG2   = 40;

  localparam logic [TOL_BITS-1:0]      TOL_RESET          = 32'd1;
  localparam logic [APB_ADDR_BITS-1:0] REG_ZERO_TOLERANCE = 1'b0;

  // Coordinate slot of matrix entry (r, c), r != c: xy, xz, xw, yz, yw, zw.
  function automatic logic [2:0] pair_idx(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [2:0] idx;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    case ({lo, hi})
      4'b0001: idx = 3'd0;
      4'b0010: idx = 3'd1;
      4'b0011: idx = 3'd2;
      4'b0110: idx = 3'd3;
      4'b0111: idx = 3'd4;
      4'b1011: idx = 3'd5;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

@@ hdl/plucker_line_line_intersect.sv @@
// Pluecker line-line intersection: pipelined product, trace test and row/column pick.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             12 line coordinates in tdata
//   m_axis    out  tvalid/tready             meet point, common plane, meet flag
//   apb       in   psel/penable/pwrite/pready zero_tolerance at address 0
//
// Five register stages: input, 36 products, matrix entries and trace halves,
// zero tests, row/column selection into the output register. One request can
// enter every cycle while the output is not stalled. Each stage takes new data
// when it is empty or its successor moves, so a stalled output holds its result
// while bubbles ahead are closed. rst clears the valid bits and sets
// zero_tolerance to 1.
module plucker_line_line_intersect
  import plli_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // plane_xy, plane_xz, plane_xw, plane_yz, plane_yw, plane_zw,
  // point_xy, point_xz, point_xw, point_yz, point_yw, point_zw
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // meet_x, meet_y, meet_z, meet_w, span_a, span_b, span_c, span_d
  output logic [OUT_DATA_BITS-1:0]              m_axis_tdata,
  // lines_meet
  output logic [0:0]                            m_axis_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [APB_ADDR_BITS-1:0]              paddr,
  input  logic [APB_DATA_BITS-1:0]              pwdata,
  output logic [APB_DATA_BITS-1:0]              prdata,
  output logic                                  pready
);

  localparam int PW = 2 * COORD_BITS;
  localparam int NW = PW + 2;
  localparam int SW = PW + 3;
  localparam int CW = (PW + 4 > TOL_BITS + 2) ? PW + 4 : TOL_BITS + 2;
  localparam int RW = (SW > TRACE_LIMIT_LOG2 + 2) ? SW : TRACE_LIMIT_LOG2 + 2;
  localparam logic signed [RW-1:0] TRACE_LIM = RW'(1) <<< TRACE_LIMIT_LOG2;

  // Configuration register.
  logic [TOL_BITS-1:0] zero_tolerance;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ZERO_TOLERANCE) ? APB_DATA_BITS'(zero_tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_ZERO_TOLERANCE) begin
      zero_tolerance <= TOL_BITS'(pwdata);
    end
  end

  // Valid bits and backpressure.
  logic [4:0] vld;
  logic [4:0] rdy;

  assign rdy[4] = !vld[4] || m_axis_tready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_axis_tvalid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
    end
  end

  // Stage 0: coordinates.
  logic signed [COORD_BITS-1:0] kc0 [NUM_COORDS];
  logic signed [COORD_BITS-1:0] lc0 [NUM_COORDS];

  for (genvar a = 0; a < NUM_COORDS; a++) begin : g_in
    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        kc0[a] <= s_axis_tdata[a*COORD_BITS +: COORD_BITS];
        lc0[a] <= s_axis_tdata[(a+NUM_COORDS)*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // Stage 1: every plane coordinate times every point coordinate.
  logic signed [PW-1:0] p1 [NUM_COORDS][NUM_COORDS];

  for (genvar a = 0; a < NUM_COORDS; a++) begin : g_pa
    for (genvar b = 0; b < NUM_COORDS; b++) begin : g_pb
      always_ff @(posedge clk) begin
        if (rdy[1]) p1[a][b] <= kc0[a] * lc0[b];
      end
    end
  end

  // Stage 2: product matrix entries and the two halves of the trace sum.
  logic signed [NW-1:0] n2 [4][4];
  logic signed [NW-1:0] tlo2;
  logic signed [NW-1:0] thi2;

  for (genvar i = 0; i < 4; i++) begin : g_ni
    for (genvar j = 0; j < 4; j++) begin : g_nj
      logic signed [NW-1:0] acc;
      logic signed [NW-1:0] term;
      always_comb begin
        acc  = '0;
        term = '0;
        for (int q = 0; q < 4; q++) begin
          if (q != i && q != j) begin
            term = NW'(p1[pair_idx(2'(i), 2'(q))][pair_idx(2'(q), 2'(j))]);
            // Entry signs follow the antisymmetric layout of both matrices.
            if ((i < q) == (q < j)) acc = acc + term;
            else                    acc = acc - term;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[2]) n2[i][j] <= acc;
      end
    end
  end

  // Trace sum s = -(sum of same-coordinate products).
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      tlo2 <= NW'(0) - NW'(p1[0][0]) - NW'(p1[1][1]) - NW'(p1[2][2]);
      thi2 <= NW'(0) - NW'(p1[3][3]) - NW'(p1[4][4]) - NW'(p1[5][5]);
    end
  end

  // Stage 3: zero tests against the tolerance.
  logic signed [CW-1:0] tol_c;
  logic signed [SW-1:0] s3;
  logic signed [RW-1:0] s3_r;
  logic signed [CW-1:0] two_s;
  logic                 meet_c;
  logic signed [NW-1:0] n3 [4][4];
  logic [3:0]           nz3 [4];
  logic                 meet3;

  assign tol_c  = $signed(CW'(zero_tolerance));
  assign s3     = SW'(tlo2) + SW'(thi2);
  assign s3_r   = RW'(s3);
  assign two_s  = CW'(s3) <<< 1;
  assign meet_c = (s3_r < TRACE_LIM) && (s3_r > -TRACE_LIM)
               && (two_s < tol_c) && (two_s > -tol_c);

  for (genvar i = 0; i < 4; i++) begin : g_zi
    for (genvar j = 0; j < 4; j++) begin : g_zj
      logic signed [CW-1:0] ev;
      assign ev = CW'(n2[i][j]);
      always_ff @(posedge clk) begin
        if (rdy[3]) begin
          n3[i][j]  <= n2[i][j];
          nz3[i][j] <= !((ev < tol_c) && (ev > -tol_c));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) meet3 <= meet_c;
  end

  // Stage 4: first nonzero row and column, falling back to the last.
  logic [3:0] row_any;
  logic [3:0] col_any;
  logic [3:0] sel_row;
  logic [3:0] sel_col;
  logic signed [OUT_BITS-1:0] pt_c [4];
  logic signed [OUT_BITS-1:0] pl_c [4];
  logic signed [OUT_BITS-1:0] pt4 [4];
  logic signed [OUT_BITS-1:0] pl4 [4];
  logic                       meet4;

  for (genvar i = 0; i < 4; i++) begin : g_any
    assign row_any[i] = |nz3[i];
    assign col_any[i] = nz3[0][i] | nz3[1][i] | nz3[2][i] | nz3[3][i];
  end

  assign sel_row[0] = row_any[0];
  assign sel_row[1] = row_any[1] && !row_any[0];
  assign sel_row[2] = row_any[2] && !row_any[1] && !row_any[0];
  assign sel_row[3] = !row_any[2] && !row_any[1] && !row_any[0];
  assign sel_col[0] = col_any[0];
  assign sel_col[1] = col_any[1] && !col_any[0];
  assign sel_col[2] = col_any[2] && !col_any[1] && !col_any[0];
  assign sel_col[3] = !col_any[2] && !col_any[1] && !col_any[0];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pt_c[j] = '0;
      pl_c[j] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (sel_row[i]) pt_c[j] = pt_c[j] | OUT_BITS'(n3[i][j]);
        if (sel_col[i]) pl_c[j] = pl_c[j] | OUT_BITS'(n3[j][i]);
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_out
    always_ff @(posedge clk) begin
      if (rdy[4]) begin
        pt4[j] <= meet3 ? pt_c[j] : '0;
        pl4[j] <= meet3 ? pl_c[j] : '0;
      end
    end
    assign m_axis_tdata[j*OUT_BITS +: OUT_BITS]     = pt4[j];
    assign m_axis_tdata[(j+4)*OUT_BITS +: OUT_BITS] = pl4[j];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) meet4 <= meet3;
  end

  assign m_axis_tvalid   = vld[4];
  assign m_axis_tuser[0] = meet4;

endmodule

@@ hdl/plli_checker.sv @@
// Port-level checks for the line intersection block, bound to its top level.
`include "plucker_line_line_intersect_assert.svh"

module plli_checker
  import plli_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic [0:0]               m_axis_tuser
);

  // A held result keeps its payload until taken.
  `PLLI_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

  // With nothing waiting at the output, no stage can be blocked.
  `PLLI_ASSERT_SAME(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready,
    "input stalled with an empty output stage")

  // Lines that miss give an all-zero point and plane.
  `PLLI_ASSERT_SAME(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata == '0, "nonzero coordinates for lines that miss")

  // Reset empties the pipeline.
  `PLLI_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid,
    "result valid right after reset")

endmodule

bind plucker_line_line_intersect plli_checker u_plli_checker (.*);
